// ===== design/hae_pkg.sv =====
// Package for the histogram auto exposure block: default sizes, field widths,
// register codes, controller/datapath command and status structs, exp table.
// No dependencies.
package hae_pkg;

    localparam int DEFAULT_BIN_COUNT  = 64;
    localparam int DEFAULT_COUNT_BITS = 22;

    localparam int GRAY_BITS    = 8;
    localparam int SHUTTER_BITS = 24;
    localparam int GAIN_BITS    = 8;
    localparam int LEVEL_BITS   = 6;
    localparam int EXP_ENTRIES  = 64;
    localparam int EXP_BITS     = 17;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 24;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MANUAL_MODE    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MANUAL_SHUTTER = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOOP_GAIN      = 2'd2;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 8'd128;

    // exp(0.55) in Q16 and exp(-1/64) in Q30
    localparam logic [63:0] EXP_AT_ZERO    = 64'd113590;
    localparam logic [63:0] STEP_RATIO_Q30 = 64'd1057095000;

    typedef logic [EXP_BITS-1:0] exp_q16_t;
    typedef exp_q16_t exp_table_t [EXP_ENTRIES];

    typedef struct packed {
        logic pix_accept;   // pixel transfer on the input side
        logic scan_clr;     // restart scan address and accumulator
        logic scan_rd;      // read next bin for the scan
        logic mul1_en;      // shutter * gain, exp factor lookup
        logic mul2_en;      // times exp factor
        logic hist_clr;     // drop the histogram and pixel count
        logic load_out;     // load the output register
    } hae_cmd_t;

    typedef struct packed {
        logic scan_last;    // scan address points at the top bin
        logic out_free;     // output register empty or being drained
    } hae_status_t;

    // exp(0.55 - k/64) in unsigned Q16, built by repeated rounded scaling
    function automatic exp_table_t build_exp_table();
        exp_table_t tbl;
        logic [63:0] e;
        e = EXP_AT_ZERO;
        for (int k = 0; k < EXP_ENTRIES; k++)
        begin
            tbl[k] = e[EXP_BITS-1:0];
            e = (e * STEP_RATIO_Q30 + 64'd536870912) >> 30;
        end
        return tbl;
    endfunction

    localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

// ===== design/hae_ctrl.sv =====
// Controller for the histogram auto exposure block: sequences pixel intake,
// bin scan, the two multiplier steps and the result hand-off.
// Depends on hae_pkg.
module hae_ctrl
    import hae_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_last,
    output logic        in_ready,
    input  hae_status_t status,
    output hae_cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_DRAIN = 7'b0000010,
        ST_SCAN  = 7'b0000100,
        ST_FLUSH = 7'b0001000,
        ST_MUL1  = 7'b0010000,
        ST_MUL2  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.pix_accept = in_valid;
                if (in_valid && in_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last pixel's bin write lands here; scan starts after it
                cmd.scan_clr = 1'b1;
                state_next   = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul1_en  = 1'b1;
                cmd.hist_clr = 1'b1;
                state_next   = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2_en = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/hae_datapath.sv =====
// Datapath for the histogram auto exposure block: config registers, bin memory
// with read-modify-write forwarding, percentile scan, shutter math, output register.
// Depends on hae_pkg.
module hae_datapath
    import hae_pkg::*;
#(
    parameter int BIN_COUNT  = DEFAULT_BIN_COUNT,
    parameter int COUNT_BITS = DEFAULT_COUNT_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  hae_cmd_t                  cmd,
    output hae_status_t               status,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic [GRAY_BITS-1:0]      gray_pixel,
    input  logic [SHUTTER_BITS-1:0]   current_shutter,
    input  logic                      last_pixel,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic [SHUTTER_BITS-1:0]   new_shutter,
    output logic [LEVEL_BITS-1:0]     level_bin
);

    localparam int BIN_BITS   = $clog2(BIN_COUNT);
    localparam int TOTAL_BITS = COUNT_BITS + 1;
    localparam int ACC_BITS   = COUNT_BITS + BIN_BITS;
    localparam int CMP_BITS   = ACC_BITS + 3;
    localparam int P1_BITS    = SHUTTER_BITS + GAIN_BITS;
    localparam int F_BITS     = EXP_BITS + 1;
    localparam int P2_BITS    = P1_BITS + 1 + F_BITS;
    localparam int SUM_BITS   = P2_BITS + 1;
    localparam int Q_BITS     = SUM_BITS - SHUTTER_BITS;

    localparam logic signed [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(64'd8388608);
    localparam logic signed [F_BITS-1:0]   ONE_Q16    = F_BITS'(65536);

    // configuration
    logic                    manual_mode_reg;
    logic [SHUTTER_BITS-1:0] manual_shutter_reg;
    logic [GAIN_BITS-1:0]    loop_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            manual_mode_reg    <= 1'b0;
            manual_shutter_reg <= '0;
            loop_gain_reg      <= GAIN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MANUAL_MODE:    manual_mode_reg    <= cfg_data[0];
                REG_MANUAL_SHUTTER: manual_shutter_reg <= cfg_data[SHUTTER_BITS-1:0];
                REG_LOOP_GAIN:      loop_gain_reg      <= cfg_data[GAIN_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // histogram memory; an entry whose valid bit is low reads as zero
    logic [COUNT_BITS-1:0] hist_mem [BIN_COUNT];
    logic [BIN_COUNT-1:0]  hist_vld_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  rd_vld_reg;

    logic [BIN_BITS+GRAY_BITS-1:0] bin_wide;
    logic [BIN_BITS-1:0]           pix_bin;
    logic [BIN_BITS-1:0]           rd_addr;

    logic                  p_vld_reg;
    logic [BIN_BITS-1:0]   p_bin_reg;
    logic                  wr_vld_reg;
    logic [BIN_BITS-1:0]   wr_bin_reg;
    logic [COUNT_BITS-1:0] wr_val_reg;
    logic [COUNT_BITS-1:0] cur_count;
    logic [COUNT_BITS-1:0] inc_count;
    logic [TOTAL_BITS-1:0] total_reg;

    logic [BIN_BITS-1:0]   scan_addr_reg;
    logic [BIN_BITS-1:0]   scan_idx_reg;
    logic                  sdat_vld_reg;
    logic [ACC_BITS-1:0]   acc_reg;
    logic [ACC_BITS-1:0]   acc_next;
    logic [CMP_BITS-1:0]   acc_x5;
    logic [CMP_BITS-1:0]   total_x4;
    logic                  found_reg;
    logic [BIN_BITS-1:0]   level_reg;

    assign bin_wide = {gray_pixel, {BIN_BITS{1'b0}}};
    assign pix_bin  = bin_wide[BIN_BITS+GRAY_BITS-1:GRAY_BITS];
    assign rd_addr  = cmd.scan_rd ? scan_addr_reg : pix_bin;

    // forward the write of the previous cycle when the same bin comes back
    always_comb
    begin
        if (wr_vld_reg && (wr_bin_reg == p_bin_reg))
        begin
            cur_count = wr_val_reg;
        end
        else if (rd_vld_reg)
        begin
            cur_count = rd_data_reg;
        end
        else
        begin
            cur_count = '0;
        end
        inc_count = (cur_count == {COUNT_BITS{1'b1}}) ? cur_count
                                                      : cur_count + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (p_vld_reg)
        begin
            hist_mem[p_bin_reg] <= inc_count;
        end
        rd_data_reg <= hist_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        p_bin_reg  <= pix_bin;
        wr_bin_reg <= p_bin_reg;
        wr_val_reg <= inc_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
            p_vld_reg    <= 1'b0;
            wr_vld_reg   <= 1'b0;
            total_reg    <= '0;
        end
        else
        begin
            rd_vld_reg <= hist_vld_reg[rd_addr];
            p_vld_reg  <= cmd.pix_accept;
            wr_vld_reg <= p_vld_reg && !cmd.hist_clr;
            if (cmd.hist_clr)
            begin
                hist_vld_reg <= '0;
                total_reg    <= '0;
            end
            else
            begin
                if (p_vld_reg)
                begin
                    hist_vld_reg[p_bin_reg] <= 1'b1;
                end
                if (cmd.pix_accept && (total_reg != {TOTAL_BITS{1'b1}}))
                begin
                    total_reg <= total_reg + 1'b1;
                end
            end
        end
    end

    // scan: running sum against 80 percent of the pixel count
    assign acc_next = acc_reg + ACC_BITS'(rd_vld_reg ? rd_data_reg : '0);
    assign acc_x5   = (CMP_BITS'(acc_next) << 2) + CMP_BITS'(acc_next);
    assign total_x4 = CMP_BITS'(total_reg) << 2;

    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_addr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg <= '0;
            sdat_vld_reg  <= 1'b0;
            acc_reg       <= '0;
            found_reg     <= 1'b0;
            level_reg     <= '0;
        end
        else
        begin
            sdat_vld_reg <= cmd.scan_rd;
            if (cmd.scan_clr)
            begin
                scan_addr_reg <= '0;
                acc_reg       <= '0;
                found_reg     <= 1'b0;
                level_reg     <= '0;
            end
            else
            begin
                if (cmd.scan_rd)
                begin
                    scan_addr_reg <= scan_addr_reg + 1'b1;
                end
                if (sdat_vld_reg && !found_reg)
                begin
                    acc_reg <= acc_next;
                    if (acc_x5 > total_x4)
                    begin
                        found_reg <= 1'b1;
                        level_reg <= scan_idx_reg;
                    end
                end
            end
        end
    end

    // shutter * (gain * (exp - 1) + 1), two registered multiplies
    logic [SHUTTER_BITS-1:0]        shutter_reg;
    logic [P1_BITS-1:0]             prod1_reg;
    logic signed [F_BITS-1:0]       f_reg;
    logic signed [P2_BITS-1:0]      prod2_reg;
    logic [BIN_BITS+5:0]            k_wide;
    logic [LEVEL_BITS-1:0]          k_idx;
    logic [BIN_BITS+5:0]            lvl_ext;
    logic signed [SUM_BITS-1:0]     sum;
    logic [Q_BITS-1:0]              quot;
    logic [SHUTTER_BITS-1:0]        auto_shutter;

    assign k_wide  = {level_reg, 6'b0} >> BIN_BITS;
    assign k_idx   = k_wide[LEVEL_BITS-1:0];
    assign lvl_ext = {6'b0, level_reg};

    always_comb
    begin
        sum = $signed({{(SUM_BITS-SHUTTER_BITS-24){1'b0}}, shutter_reg, 24'b0})
            + SUM_BITS'(prod2_reg) + ROUND_HALF;
        quot = sum[SUM_BITS-1] ? '0 : sum[SUM_BITS-1:SUM_BITS-Q_BITS];
        if (|quot[Q_BITS-1:SHUTTER_BITS])
        begin
            auto_shutter = {SHUTTER_BITS{1'b1}};
        end
        else
        begin
            auto_shutter = quot[SHUTTER_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pix_accept && last_pixel)
        begin
            shutter_reg <= current_shutter;
        end
        if (cmd.mul1_en)
        begin
            prod1_reg <= P1_BITS'(shutter_reg) * P1_BITS'(loop_gain_reg);
            f_reg     <= $signed({1'b0, EXP_TABLE[k_idx]}) - ONE_Q16;
        end
        if (cmd.mul2_en)
        begin
            prod2_reg <= $signed({1'b0, prod1_reg}) * f_reg;
        end
        if (cmd.load_out)
        begin
            new_shutter <= manual_mode_reg ? manual_shutter_reg : auto_shutter;
            level_bin   <= lvl_ext[LEVEL_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    assign status = '{scan_last: (scan_addr_reg == BIN_BITS'(BIN_COUNT - 1)),
                      out_free:  (!out_valid || out_ready)};

    // scan reads and pixel writes share the memory port: never together
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_rd |-> !p_vld_reg && !cmd.pix_accept)
        else $error("scan read overlaps pixel update");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hist_clr |=> (total_reg == '0) && (hist_vld_reg == '0))
        else $error("histogram not cleared");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !out_valid || out_ready)
        else $error("pending result overwritten");

    assert property (@(posedge clk) disable iff (!rst_n)
        found_reg && !cmd.scan_clr |=> found_reg && $stable(level_reg))
        else $error("scan level changed after hit");

endmodule

// ===== design/histogram_auto_exposure.sv =====
// Histogram percentile auto exposure. Pixels: one transfer per cycle while
// collecting. After the last pixel the bins are scanned, one per cycle, from
// the bin memory read port; the result then goes through the flush, mul1 and
// mul2 states, and input stays stalled until it is loaded for output.
// Reset (rst_n, async, active low) empties the histogram and loads register
// defaults: auto mode, manual shutter 0, loop gain 128.
module histogram_auto_exposure
    import hae_pkg::*;
#(
    parameter int BIN_COUNT  = DEFAULT_BIN_COUNT,   // power of two, 16..256
    parameter int COUNT_BITS = DEFAULT_COUNT_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [31:0]               s_axis_tdata,  // gray_pixel, current_shutter
    input  logic                      s_axis_tlast,  // last_pixel
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [31:0]               m_axis_tdata,  // new_shutter, level_bin, 2'b0
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    hae_cmd_t                cmd;
    hae_status_t             status;
    logic [SHUTTER_BITS-1:0] new_shutter;
    logic [LEVEL_BITS-1:0]   level_bin;

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = {2'b0, level_bin, new_shutter};

    hae_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hae_datapath #(
        .BIN_COUNT  (BIN_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_write       (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .gray_pixel      (s_axis_tdata[GRAY_BITS-1:0]),
        .current_shutter (s_axis_tdata[GRAY_BITS+SHUTTER_BITS-1:GRAY_BITS]),
        .last_pixel      (s_axis_tlast),
        .out_ready       (m_axis_tready),
        .out_valid       (m_axis_tvalid),
        .new_shutter     (new_shutter),
        .level_bin       (level_bin)
    );

endmodule
